[rtl/core/nlt_pkg.sv]
// ----------------------------------------------------------------------------
// nlt_pkg: shared types and constants of the node lease tracker
// Command and status codes, node record layout, sequencer states and the
// request and response payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlt_pkg;

	// payload field widths
	localparam int ADDR_W       = 48;
	localparam int SIZE_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 4;
	localparam int SIDX_W       = 10;
	localparam int NODE_CNT_W   = 10;
	localparam int TOTAL_W      = 32;
	localparam int USED_PAGES_W = 11;

	// page geometry
	localparam int PAGE_SHIFT = 12;

	// default sizing of the region and of the record store
	localparam int DEF_REGION_PAGES = 1024;
	localparam int DEF_MAX_NODES    = 512;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CARVE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ISSUE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STATS   = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK          = 4'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE    = 4'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_SIZE    = 4'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_ADDR    = 4'd3;
	localparam logic [STATUS_W-1:0] STS_UNMAPPED    = 4'd4;
	localparam logic [STATUS_W-1:0] STS_NOT_START   = 4'd5;
	localparam logic [STATUS_W-1:0] STS_BAD_ISSUE   = 4'd6;
	localparam logic [STATUS_W-1:0] STS_BAD_RELEASE = 4'd7;
	localparam logic [STATUS_W-1:0] STS_BAD_DISCARD = 4'd8;

	// node record layout: size index, flags, start page above them
	localparam int REC_SIDX_LSB  = 0;
	localparam int REC_LIVE_BIT  = 10;
	localparam int REC_REL_BIT   = 11;
	localparam int REC_DISC_BIT  = 12;
	localparam int REC_START_LSB = 13;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ROOM,
		ST_FIT,
		ST_FILL,
		ST_PLACE,
		ST_RANGE,
		ST_MAPPED,
		ST_OWNER,
		ST_RECORD,
		ST_RESULT
	} nlt_state_t;

	// input item
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] node_address;
		logic [SIZE_W-1:0] size_bytes;
	} nlt_req_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [ADDR_W-1:0]       result_address;
		logic [SIDX_W-1:0]       size_index;
		logic                    revoked;
		logic [NODE_CNT_W-1:0]   node_count;
		logic [TOTAL_W-1:0]      reuse_count;
		logic [TOTAL_W-1:0]      release_count;
		logic [TOTAL_W-1:0]      discard_count;
		logic [USED_PAGES_W-1:0] used_pages;
	} nlt_rsp_t;

endpackage

`default_nettype wire

[rtl/core/node_lease_tracker_unit.sv]
// ----------------------------------------------------------------------------
// node_lease_tracker_unit: page-granular node carving and lease tracking
// Carves nodes from a payload region with a bump pointer, keeps a page map
// and per-node records, and tracks issue, release and discard of nodes.
// ----------------------------------------------------------------------------
// Usage:
// - a command transfer happens on a rising edge with start high and busy low;
//   busy stays high until the result has been shown
// - each result is on response for one cycle, marked by done; the receiver
//   cannot stall, so it must take the result in that cycle
// - the user must write configuration (protected mode, region base) through
//   cfg_valid/cfg_index/cfg_data only while idle; the block does not enforce
//   it, and cfg_ready is always high
// - stats and undefined commands go to the result; a carve runs room, fit,
//   fill, place; issue/release/discard run range, mapped, owner, record
// - one 48-bit add/subtract unit does the address arithmetic and range compares, one
//   step per cycle; a carve writes one page-map entry per cycle
// - page map entries at or above the carve cursor read as unmapped, so reset
//   needs no clearing pass; reset clears the cursor, counters and config
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module node_lease_tracker_unit #(
	parameter int REGION_PAGES = nlt_pkg::DEF_REGION_PAGES,
	parameter int MAX_NODES    = nlt_pkg::DEF_MAX_NODES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire nlt_pkg::nlt_req_t             request,
	output logic                               done,
	output nlt_pkg::nlt_rsp_t                  response,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [nlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nlt_pkg::ADDR_W-1:0]    cfg_data
);

	localparam int AW     = nlt_pkg::ADDR_W;
	localparam int PS     = nlt_pkg::PAGE_SHIFT;
	localparam int PAGE_W = $clog2(REGION_PAGES);
	localparam int CUR_W  = $clog2(REGION_PAGES + 1);
	localparam int NODE_W = $clog2(MAX_NODES + 1);
	localparam int OWN_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int REC_W  = nlt_pkg::REC_START_LSB + PAGE_W;
	localparam int PGS_W  = nlt_pkg::SIZE_W - PS;

	// control state
	nlt_pkg::nlt_state_t state_q, state_d;
	logic [CUR_W-1:0]               cursor_q;
	logic [NODE_W-1:0]              nodes_q;
	logic [nlt_pkg::TOTAL_W-1:0]    reuse_q, release_q, discard_q;
	logic                           protected_q;
	logic [AW-1:0]                  base_q;

	// datapath registers
	nlt_pkg::nlt_req_t              req_q;
	logic [AW-1:0]                  diff_q;
	logic [CUR_W-1:0]               room_q;
	logic [CUR_W-1:0]               fill_q;
	logic [PAGE_W-1:0]              start_q;
	logic [nlt_pkg::STATUS_W-1:0]   status_q;
	logic [AW-1:0]                  res_addr_q;
	logic [nlt_pkg::SIDX_W-1:0]     sidx_q;
	logic                           revoked_q;

	// memories
	logic [OWN_W-1:0]               page_owner [REGION_PAGES];
	logic [REC_W-1:0]               node_record [MAX_NODES];
	logic [OWN_W-1:0]               own_rd_q;
	logic [REC_W-1:0]               rec_rd_q;

	// shared add/subtract unit
	logic [AW-1:0]                  alu_a, alu_b;
	logic                           alu_sub;
	logic [AW:0]                    alu_res;
	logic                           alu_borrow;

	// decode and record checks
	logic [AW-1:0]                  base_aligned;
	logic [PGS_W-1:0]               pages_w;
	logic                           size_bad, nodes_full, unaligned, is_lookup;
	logic [AW-1:0]                  page_ext;
	logic [PAGE_W-1:0]              page_idx;
	logic                           rec_live, rec_rel, rec_disc, start_ok, flag_bad, rec_ok;
	logic [REC_W-1:0]               upd_rec;
	logic [nlt_pkg::STATUS_W-1:0]   rec_status;

	// memory write controls
	logic                           own_we, rec_we;
	logic [OWN_W-1:0]               rec_waddr;
	logic [REC_W-1:0]               rec_wdata;
	logic [REC_W-1:0]               carve_rec;

	// output widening
	logic [31:0]                    node_cnt_ext, used_ext;

	// item decode
	assign base_aligned = {base_q[AW-1:PS], {PS{1'b0}}};
	assign pages_w      = req_q.size_bytes[nlt_pkg::SIZE_W-1:PS];
	assign size_bad     = (req_q.size_bytes[nlt_pkg::SIZE_W-1:PS+1] == '0) ||
		(req_q.size_bytes[PS-1:0] != '0);
	assign nodes_full   = nodes_q >= NODE_W'(MAX_NODES);
	assign unaligned    = req_q.node_address[PS-1:0] != '0;
	assign is_lookup    = req_q.command inside {nlt_pkg::CMD_ISSUE, nlt_pkg::CMD_RELEASE,
		nlt_pkg::CMD_DISCARD};
	assign page_ext     = AW'(diff_q[AW-1:PS]);
	assign page_idx     = diff_q[PS +: PAGE_W];

	// shared arithmetic unit
	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) :
		({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_res[AW];

	// record checks for issue, release and discard
	always_comb begin
		rec_live = rec_rd_q[nlt_pkg::REC_LIVE_BIT];
		rec_rel  = rec_rd_q[nlt_pkg::REC_REL_BIT];
		rec_disc = rec_rd_q[nlt_pkg::REC_DISC_BIT];
		start_ok = rec_rd_q[nlt_pkg::REC_START_LSB +: PAGE_W] == page_idx;
		upd_rec  = rec_rd_q;
		flag_bad = 1'b1;
		rec_status = nlt_pkg::STS_BAD_ISSUE;
		case (req_q.command)
			nlt_pkg::CMD_ISSUE: begin
				flag_bad = rec_live | rec_disc;
				rec_status = nlt_pkg::STS_BAD_ISSUE;
				upd_rec[nlt_pkg::REC_LIVE_BIT] = 1'b1;
			end
			nlt_pkg::CMD_RELEASE: begin
				flag_bad = !rec_live | rec_disc;
				rec_status = nlt_pkg::STS_BAD_RELEASE;
				upd_rec[nlt_pkg::REC_LIVE_BIT] = 1'b0;
				upd_rec[nlt_pkg::REC_REL_BIT] = 1'b1;
			end
			nlt_pkg::CMD_DISCARD: begin
				flag_bad = rec_live | rec_disc;
				rec_status = nlt_pkg::STS_BAD_DISCARD;
				upd_rec[nlt_pkg::REC_DISC_BIT] = 1'b1;
			end
			default: begin
				flag_bad = 1'b1;
			end
		endcase
		if (!start_ok) begin
			rec_status = nlt_pkg::STS_NOT_START;
		end else if (!flag_bad) begin
			rec_status = nlt_pkg::STS_OK;
		end
		rec_ok = start_ok && !flag_bad;
	end

	// new record for a carve
	assign carve_rec = {cursor_q[PAGE_W-1:0], 3'b000,
		nlt_pkg::SIDX_W'(pages_w - PGS_W'(1))};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nlt_pkg::ST_IDLE: begin
				if (start) state_d = nlt_pkg::ST_DISPATCH;
			end
			nlt_pkg::ST_DISPATCH: begin
				if (req_q.command == nlt_pkg::CMD_CARVE) begin
					state_d = (size_bad || nodes_full) ? nlt_pkg::ST_RESULT : nlt_pkg::ST_ROOM;
				end else if (is_lookup) begin
					state_d = (alu_borrow || unaligned) ? nlt_pkg::ST_RESULT :
						nlt_pkg::ST_RANGE;
				end else begin
					state_d = nlt_pkg::ST_RESULT;
				end
			end
			nlt_pkg::ST_ROOM:   state_d = nlt_pkg::ST_FIT;
			nlt_pkg::ST_FIT:    state_d = alu_borrow ? nlt_pkg::ST_RESULT : nlt_pkg::ST_FILL;
			nlt_pkg::ST_FILL: begin
				if (fill_q == CUR_W'(1)) state_d = nlt_pkg::ST_PLACE;
			end
			nlt_pkg::ST_PLACE:  state_d = nlt_pkg::ST_RESULT;
			nlt_pkg::ST_RANGE:  state_d = alu_borrow ? nlt_pkg::ST_MAPPED : nlt_pkg::ST_RESULT;
			nlt_pkg::ST_MAPPED: state_d = alu_borrow ? nlt_pkg::ST_OWNER : nlt_pkg::ST_RESULT;
			nlt_pkg::ST_OWNER:  state_d = nlt_pkg::ST_RECORD;
			nlt_pkg::ST_RECORD: state_d = nlt_pkg::ST_RESULT;
			nlt_pkg::ST_RESULT: state_d = nlt_pkg::ST_IDLE;
			default:            state_d = nlt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: unit operands, memory writes, handshake
	always_comb begin
		alu_a     = req_q.node_address;
		alu_b     = base_aligned;
		alu_sub   = 1'b1;
		own_we    = 1'b0;
		rec_we    = 1'b0;
		rec_waddr = nodes_q[OWN_W-1:0];
		rec_wdata = carve_rec;
		busy      = state_q != nlt_pkg::ST_IDLE;
		done      = state_q == nlt_pkg::ST_RESULT;
		case (state_q)
			nlt_pkg::ST_ROOM: begin
				alu_a = AW'(REGION_PAGES);
				alu_b = AW'(cursor_q);
			end
			nlt_pkg::ST_FIT: begin
				alu_a  = AW'(room_q);
				alu_b  = AW'(pages_w);
				rec_we = !alu_borrow;
			end
			nlt_pkg::ST_FILL: begin
				own_we = 1'b1;
			end
			nlt_pkg::ST_PLACE: begin
				alu_a   = base_aligned;
				alu_b   = AW'({start_q, {PS{1'b0}}});
				alu_sub = 1'b0;
			end
			nlt_pkg::ST_RANGE: begin
				alu_a = page_ext;
				alu_b = AW'(REGION_PAGES);
			end
			nlt_pkg::ST_MAPPED: begin
				alu_a = page_ext;
				alu_b = AW'(cursor_q);
			end
			nlt_pkg::ST_RECORD: begin
				rec_we    = rec_ok;
				rec_waddr = own_rd_q;
				rec_wdata = upd_rec;
			end
			default: begin
				alu_sub = 1'b1;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// control registers, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nlt_pkg::ST_IDLE;
			cursor_q    <= '0;
			nodes_q     <= '0;
			reuse_q     <= '0;
			release_q   <= '0;
			discard_q   <= '0;
			protected_q <= 1'b0;
			base_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nlt_pkg::CFG_PROTECTED:   protected_q <= cfg_data[0];
					nlt_pkg::CFG_REGION_BASE: base_q <= cfg_data;
					default:                  protected_q <= protected_q;
				endcase
			end
			if (state_q == nlt_pkg::ST_FILL) begin
				cursor_q <= cursor_q + CUR_W'(1);
			end
			if (state_q == nlt_pkg::ST_PLACE) begin
				nodes_q <= nodes_q + NODE_W'(1);
			end
			if (state_q == nlt_pkg::ST_RECORD && rec_ok) begin
				case (req_q.command)
					nlt_pkg::CMD_ISSUE: begin
						if (rec_rel) reuse_q <= reuse_q + 32'd1;
					end
					nlt_pkg::CMD_RELEASE: release_q <= release_q + 32'd1;
					nlt_pkg::CMD_DISCARD: discard_q <= discard_q + 32'd1;
					default:              reuse_q <= reuse_q;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			nlt_pkg::ST_IDLE: begin
				if (start) req_q <= request;
			end
			nlt_pkg::ST_DISPATCH: begin
				status_q   <= nlt_pkg::STS_OK;
				res_addr_q <= '0;
				sidx_q     <= '0;
				revoked_q  <= 1'b0;
				diff_q     <= alu_res[AW-1:0];
				if (req_q.command == nlt_pkg::CMD_CARVE) begin
					if (size_bad) status_q <= nlt_pkg::STS_BAD_SIZE;
					else if (nodes_full) status_q <= nlt_pkg::STS_NO_SPACE;
				end else if (is_lookup && (alu_borrow || unaligned)) begin
					status_q <= nlt_pkg::STS_BAD_ADDR;
				end
			end
			nlt_pkg::ST_ROOM: begin
				room_q <= alu_res[CUR_W-1:0];
			end
			nlt_pkg::ST_FIT: begin
				fill_q  <= pages_w[CUR_W-1:0];
				start_q <= cursor_q[PAGE_W-1:0];
				if (alu_borrow) status_q <= nlt_pkg::STS_NO_SPACE;
				else sidx_q <= nlt_pkg::SIDX_W'(pages_w - PGS_W'(1));
			end
			nlt_pkg::ST_FILL: begin
				fill_q <= fill_q - CUR_W'(1);
			end
			nlt_pkg::ST_PLACE: begin
				res_addr_q <= alu_res[AW-1:0];
			end
			nlt_pkg::ST_RANGE: begin
				if (!alu_borrow) status_q <= nlt_pkg::STS_BAD_ADDR;
			end
			nlt_pkg::ST_MAPPED: begin
				if (!alu_borrow) status_q <= nlt_pkg::STS_UNMAPPED;
			end
			nlt_pkg::ST_RECORD: begin
				status_q <= rec_status;
				if (rec_ok) begin
					res_addr_q <= req_q.node_address;
					sidx_q     <= rec_rd_q[nlt_pkg::REC_SIDX_LSB +: nlt_pkg::SIDX_W];
					revoked_q  <= protected_q;
				end
			end
			default: begin
				diff_q <= diff_q;
			end
		endcase
	end

	// page map: write during carve fill, registered read at the looked-up page
	always_ff @(posedge clk) begin
		if (own_we) page_owner[cursor_q[PAGE_W-1:0]] <= nodes_q[OWN_W-1:0];
		own_rd_q <= page_owner[page_idx];
	end

	// node records: registered read at the owner from the page map
	always_ff @(posedge clk) begin
		if (rec_we) node_record[rec_waddr] <= rec_wdata;
		rec_rd_q <= node_record[own_rd_q];
	end

	// result fields
	assign node_cnt_ext = 32'(nodes_q);
	assign used_ext     = 32'(cursor_q);

	always_comb begin
		response.status         = status_q;
		response.result_address = res_addr_q;
		response.size_index     = sidx_q;
		response.revoked        = revoked_q;
		response.node_count     = node_cnt_ext[nlt_pkg::NODE_CNT_W-1:0];
		response.reuse_count    = reuse_q;
		response.release_count  = release_q;
		response.discard_count  = discard_q;
		response.used_pages     = used_ext[nlt_pkg::USED_PAGES_W-1:0];
	end

	// checks
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not start the sequencer");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(REGION_PAGES))
		else $error("carve cursor ran past the region");

	a_nodes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= NODE_W'(MAX_NODES))
		else $error("node count ran past the record store");

	a_fill_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nlt_pkg::ST_FILL) |=> (cursor_q == $past(cursor_q) + CUR_W'(1)))
		else $error("page fill did not advance the cursor");

endmodule

`default_nettype wire
